[rtl/pfba_pkg.sv]
// Package with the constants, codes and item types of the page frame bitmap allocator.
`default_nettype none

package pfba_pkg;

    localparam int TOTAL_FRAMES  = 16384;
    localparam int PINNED_FRAMES = 1024;
    localparam int FRAME_SHIFT   = 12;

    localparam int MAP_WORDS = (TOTAL_FRAMES + 31) / 32;
    localparam int WORD_W    = $clog2(MAP_WORDS);
    localparam int FRAME_W   = WORD_W + 5;
    localparam int RUN_W     = 17;
    localparam int RES_LIMIT = (PINNED_FRAMES > TOTAL_FRAMES) ? TOTAL_FRAMES : PINNED_FRAMES;
    localparam int LIM_WORD  = RES_LIMIT / 32;
    localparam int LIM_BIT   = RES_LIMIT % 32;
    localparam int TAIL_BITS = TOTAL_FRAMES % 32;

    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 26;
    localparam int FREE_W   = 15;

    localparam logic [31:0] INIT_PARTIAL = (32'h1 << LIM_BIT) - 32'h1;
    localparam logic [31:0] PAD_MASK =
        (TAIL_BITS == 0) ? 32'h0 : ~((32'h1 << TAIL_BITS) - 32'h1);
    localparam logic [31:0] ALIGN_MASK = (32'h1 << FRAME_SHIFT) - 32'h1;
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);
    localparam logic [FREE_W-1:0] FREE_INIT = FREE_W'(TOTAL_FRAMES - RES_LIMIT);

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_REINIT = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_UNALIGNED = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NORUN     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_WORD,
        S_SCAN_BIT,
        S_MARK_RD,
        S_MARK_WR
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [31:0] base_address;
        logic [15:0] frame_count;
    } t_request;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] run_address;
        logic [FREE_W-1:0] free_frames;
    } t_result;

endpackage

`default_nettype wire

[rtl/page_frame_bitmap_allocator_unit.sv]
// Top level of the first-fit page frame bitmap allocator with its bitmap memory and sequencer.
//
//  Channel   Ports                     Handshake
//  request   i_request, start, busy    item taken when start is high and busy is low
//  result    o_result, o_done          item shown for one cycle while o_done is high
//
// After reset and after a reinit item the sequencer writes every bitmap word, one per
// cycle, and busy stays high until all MAP_WORDS words (512 with the default sizes) are written.
// A rejected or trivial item answers in the next cycle.  A free reads and then rewrites
// each bitmap word that the run touches.  An allocate reads each word scanned, steps through
// the bits of each word that is neither full nor empty, and reads and rewrites each word marked.
// These steps follow from the single-port bitmap memory, whose read precedes the update.
// The receiver cannot stall: o_done is high for one cycle per item.
`default_nettype none

module page_frame_bitmap_allocator_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire pfba_pkg::t_request i_request,
    output logic                   busy,
    output logic                   o_done,
    output pfba_pkg::t_result      o_result
);

    logic [31:0] r_map [pfba_pkg::MAP_WORDS];
    logic [31:0] r_rdata;

    pfba_pkg::t_state                r_state, n_state;
    logic [pfba_pkg::WORD_W-1:0]     r_word, n_word;
    logic [4:0]                      r_bit, n_bit;
    logic [31:0]                     r_cur, n_cur;
    logic [pfba_pkg::RUN_W-1:0]      r_run, n_run;
    logic [15:0]                     r_n, n_n;
    logic [pfba_pkg::FRAME_W-1:0]    r_start, n_start;
    logic [pfba_pkg::FRAME_W-1:0]    r_end, n_end;
    logic                            r_clear, n_clear;
    logic                            r_report, n_report;
    logic [pfba_pkg::FREE_W-1:0]     r_free, n_free;
    logic                            r_done, n_done;
    pfba_pkg::t_result               r_result, n_result;

    logic                            mem_we;
    logic [31:0]                     mem_wdata;

    logic [31:0]                     scan_word;
    logic [31:0]                     init_word;
    logic [pfba_pkg::RUN_W-1:0]      run_sum;
    logic [pfba_pkg::FRAME_W-1:0]    found_start;
    logic [4:0]                      lo_bit, hi_bit;
    logic [31:0]                     run_mask;
    logic [pfba_pkg::FREE_W-1:0]     pop_cnt;
    logic [63:0]                     addr_wide;
    logic [31:0]                     req_frame;
    logic                            req_range_bad;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[r_word] <= mem_wdata;
        end
        r_rdata <= r_map[r_word];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfba_pkg::S_INIT;
            r_word   <= '0;
            r_report <= 1'b0;
            r_free   <= pfba_pkg::FREE_INIT;
            r_done   <= 1'b0;
            r_clear  <= 1'b0;
            r_run    <= '0;
            r_bit    <= '0;
        end else begin
            r_state  <= n_state;
            r_word   <= n_word;
            r_report <= n_report;
            r_free   <= n_free;
            r_done   <= n_done;
            r_clear  <= n_clear;
            r_run    <= n_run;
            r_bit    <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_n      <= n_n;
        r_start  <= n_start;
        r_end    <= n_end;
        r_result <= n_result;
    end

    always_comb begin
        if (32'(r_word) < 32'(pfba_pkg::LIM_WORD)) begin
            init_word = 32'hFFFF_FFFF;
        end else if (32'(r_word) == 32'(pfba_pkg::LIM_WORD)) begin
            init_word = pfba_pkg::INIT_PARTIAL;
        end else begin
            init_word = 32'h0;
        end
        scan_word = r_rdata | ((r_word == pfba_pkg::LAST_WORD) ? pfba_pkg::PAD_MASK : 32'h0);
        run_sum = r_run + pfba_pkg::RUN_W'(32);
        found_start = (r_run == '0) ? {r_word, 5'd0} : r_start;
        lo_bit = (r_word == r_start[pfba_pkg::FRAME_W-1:5]) ? r_start[4:0] : 5'd0;
        hi_bit = (r_word == r_end[pfba_pkg::FRAME_W-1:5]) ? r_end[4:0] : 5'd31;
        run_mask = (32'hFFFF_FFFF << lo_bit) & (32'hFFFF_FFFF >> (5'd31 - hi_bit));
        pop_cnt = pfba_pkg::FREE_W'($countones(r_rdata & run_mask));
        addr_wide = 64'(r_start) << pfba_pkg::FRAME_SHIFT;
        req_frame = i_request.base_address >> pfba_pkg::FRAME_SHIFT;
        req_range_bad = (req_frame < 32'(pfba_pkg::PINNED_FRAMES))
            || (req_frame >= 32'(pfba_pkg::TOTAL_FRAMES))
            || (33'(i_request.frame_count) > (33'(pfba_pkg::TOTAL_FRAMES) - 33'(req_frame)));
    end

    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_bit    = r_bit;
        n_cur    = r_cur;
        n_run    = r_run;
        n_n      = r_n;
        n_start  = r_start;
        n_end    = r_end;
        n_clear  = r_clear;
        n_report = r_report;
        n_free   = r_free;
        n_done   = 1'b0;
        n_result = r_result;
        mem_we    = 1'b0;
        mem_wdata = init_word;

        case (r_state)
            pfba_pkg::S_IDLE: begin
                if (start) begin
                    n_result.run_address = '0;
                    n_result.free_frames = r_free;
                    case (i_request.action)
                        pfba_pkg::ACT_ALLOC: begin
                            n_n = i_request.frame_count;
                            if (i_request.frame_count == 16'd0) begin
                                n_done = 1'b1;
                                n_result.status = pfba_pkg::ST_ZERO;
                            end else if (32'(i_request.frame_count) >
                                         32'(pfba_pkg::TOTAL_FRAMES)) begin
                                n_done = 1'b1;
                                n_result.status = pfba_pkg::ST_NORUN;
                            end else begin
                                n_word  = '0;
                                n_run   = '0;
                                n_clear = 1'b0;
                                n_state = pfba_pkg::S_SCAN_RD;
                            end
                        end
                        pfba_pkg::ACT_FREE: begin
                            n_n = i_request.frame_count;
                            n_start = pfba_pkg::FRAME_W'(req_frame);
                            n_end = pfba_pkg::FRAME_W'(req_frame
                                + 32'(i_request.frame_count) - 32'd1);
                            if (i_request.frame_count == 16'd0) begin
                                n_done = 1'b1;
                                n_result.status = pfba_pkg::ST_ZERO;
                            end else if ((i_request.base_address & pfba_pkg::ALIGN_MASK)
                                         != 32'h0) begin
                                n_done = 1'b1;
                                n_result.status = pfba_pkg::ST_UNALIGNED;
                            end else if (req_range_bad) begin
                                n_done = 1'b1;
                                n_result.status = pfba_pkg::ST_RANGE;
                            end else begin
                                n_word  = req_frame[pfba_pkg::FRAME_W-1:5];
                                n_clear = 1'b1;
                                n_state = pfba_pkg::S_MARK_RD;
                            end
                        end
                        default: begin
                            n_word   = '0;
                            n_report = 1'b1;
                            n_state  = pfba_pkg::S_INIT;
                        end
                    endcase
                end
            end
            pfba_pkg::S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = init_word;
                if (r_word == pfba_pkg::LAST_WORD) begin
                    n_state  = pfba_pkg::S_IDLE;
                    n_free   = pfba_pkg::FREE_INIT;
                    n_report = 1'b0;
                    n_done   = r_report;
                    n_result.status      = pfba_pkg::ST_OK;
                    n_result.run_address = '0;
                    n_result.free_frames = pfba_pkg::FREE_INIT;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            pfba_pkg::S_SCAN_RD: begin
                n_state = pfba_pkg::S_SCAN_WORD;
            end
            pfba_pkg::S_SCAN_WORD: begin
                if (scan_word == 32'hFFFF_FFFF || scan_word == 32'h0) begin
                    if (scan_word == 32'h0 && run_sum >= pfba_pkg::RUN_W'(r_n)) begin
                        n_start = found_start;
                        n_end   = pfba_pkg::FRAME_W'(32'(found_start) + 32'(r_n) - 32'd1);
                        n_word  = found_start[pfba_pkg::FRAME_W-1:5];
                        n_state = pfba_pkg::S_MARK_RD;
                    end else begin
                        if (scan_word == 32'h0) begin
                            n_start = found_start;
                            n_run   = run_sum;
                        end else begin
                            n_run = '0;
                        end
                        if (r_word == pfba_pkg::LAST_WORD) begin
                            n_state = pfba_pkg::S_IDLE;
                            n_done  = 1'b1;
                            n_result.status      = pfba_pkg::ST_NORUN;
                            n_result.run_address = '0;
                            n_result.free_frames = r_free;
                        end else begin
                            n_word  = r_word + 1'b1;
                            n_state = pfba_pkg::S_SCAN_RD;
                        end
                    end
                end else begin
                    n_cur   = scan_word;
                    n_bit   = '0;
                    n_state = pfba_pkg::S_SCAN_BIT;
                end
            end
            pfba_pkg::S_SCAN_BIT: begin
                if (r_cur[r_bit]) begin
                    n_run = '0;
                end else begin
                    if (r_run == '0) begin
                        n_start = {r_word, r_bit};
                    end
                    n_run = r_run + 1'b1;
                end
                if (!r_cur[r_bit] && (r_run + 1'b1) == pfba_pkg::RUN_W'(r_n)) begin
                    n_end = pfba_pkg::FRAME_W'(32'(n_start) + 32'(r_n) - 32'd1);
                    n_word  = n_start[pfba_pkg::FRAME_W-1:5];
                    n_state = pfba_pkg::S_MARK_RD;
                end else if (r_bit == 5'd31) begin
                    if (r_word == pfba_pkg::LAST_WORD) begin
                        n_state = pfba_pkg::S_IDLE;
                        n_done  = 1'b1;
                        n_result.status      = pfba_pkg::ST_NORUN;
                        n_result.run_address = '0;
                        n_result.free_frames = r_free;
                    end else begin
                        n_word  = r_word + 1'b1;
                        n_state = pfba_pkg::S_SCAN_RD;
                    end
                end else begin
                    n_bit = r_bit + 1'b1;
                end
            end
            pfba_pkg::S_MARK_RD: begin
                n_state = pfba_pkg::S_MARK_WR;
            end
            pfba_pkg::S_MARK_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_clear ? (r_rdata & ~run_mask) : (r_rdata | run_mask);
                if (r_clear) begin
                    n_free = r_free + pop_cnt;
                end
                if (r_word == r_end[pfba_pkg::FRAME_W-1:5]) begin
                    n_state = pfba_pkg::S_IDLE;
                    n_done  = 1'b1;
                    n_result.status = pfba_pkg::ST_OK;
                    if (r_clear) begin
                        n_result.run_address = '0;
                        n_result.free_frames = r_free + pop_cnt;
                    end else begin
                        n_free = r_free - r_n[pfba_pkg::FREE_W-1:0];
                        n_result.run_address = addr_wide[pfba_pkg::ADDR_W-1:0];
                        n_result.free_frames = r_free - r_n[pfba_pkg::FREE_W-1:0];
                    end
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = pfba_pkg::S_MARK_RD;
                end
            end
            default: begin
                n_state = pfba_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != pfba_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire
